// File: design/msm_pkg.sv
package msm_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int ALPHABET_DEF   = 128;
    localparam int NUM_LABELS_DEF = 64;

    localparam int MASK_W  = 64;
    localparam int COUNT_W = 11;

    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_BUILD   = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;

    localparam logic RK_TEXT  = 1'b0;
    localparam logic RK_BUILD = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] symbol;
        logic [5:0] country_id;
        logic       final_item;
    } item_t;

    typedef struct packed {
        logic              result_kind;
        logic [MASK_W-1:0] found_mask;
        logic [COUNT_W-1:0] nodes_used;
        logic              overflow;
    } result_t;

endpackage

// File: design/multi_pattern_string_matcher.sv
// a repeated build answers from idle; the result strobe rises the cycle after the last
// word's work ends; one word at a time, an ascii text byte doing a transition read then
// a dependent output-mask read on synchronous memories; build reads and checks each
// root symbol, then per node pops and reads the failure link, and per transition reads,
// checks and reads the failure entry, merging output masks when a child exists
// reset: busy while clearing transition and mask memories; the receiver cannot stall
module multi_pattern_string_matcher #(
    parameter int MAX_NODES  = msm_pkg::MAX_NODES_DEF,
    parameter int ALPHABET   = msm_pkg::ALPHABET_DEF,
    parameter int NUM_LABELS = msm_pkg::NUM_LABELS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  msm_pkg::item_t   item,
    output logic             done,
    output msm_pkg::result_t result
);

    localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int SYM_W   = $clog2(ALPHABET);
    localparam int T_DEPTH = MAX_NODES * ALPHABET;
    localparam int TA_W    = $clog2(T_DEPTH);

    typedef enum logic [16:0] {
        S_CLEAR      = 17'b00000000000000001,
        S_IDLE       = 17'b00000000000000010,
        S_PAT_RD     = 17'b00000000000000100,
        S_PAT_END    = 17'b00000000000001000,
        S_PAT_MRD    = 17'b00000000000010000,
        S_SCAN_RD    = 17'b00000000000100000,
        S_SCAN_MRD   = 17'b00000000001000000,
        S_B_ROOT_RD  = 17'b00000000010000000,
        S_B_ROOT_CHK = 17'b00000000100000000,
        S_B_POP      = 17'b00000001000000000,
        S_B_FAIL     = 17'b00000010000000000,
        S_B_FU       = 17'b00000100000000000,
        S_B_RD       = 17'b00001000000000000,
        S_B_CHK      = 17'b00010000000000000,
        S_B_FRD      = 17'b00100000000000000,
        S_B_M1       = 17'b01000000000000000,
        S_B_M2       = 17'b10000000000000000
    } state_t;

    // memories
    logic [CNT_W-1:0]          tmem [T_DEPTH];
    logic [msm_pkg::MASK_W-1:0] mmem [MAX_NODES];
    logic [NODE_W-1:0]         fmem [MAX_NODES];
    logic [NODE_W-1:0]         qmem [MAX_NODES];

    logic [TA_W-1:0]  t_raddr, t_waddr;
    logic [CNT_W-1:0] t_rdata, t_wdata;
    logic             t_we;
    logic [NODE_W-1:0] m_raddr, m_waddr;
    logic [msm_pkg::MASK_W-1:0] m_rdata, m_wdata;
    logic             m_we;
    logic [NODE_W-1:0] f_raddr, f_waddr, f_rdata, f_wdata;
    logic             f_we;
    logic [NODE_W-1:0] q_raddr, q_waddr, q_rdata, q_wdata;
    logic             q_we;

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tmem[t_waddr] <= t_wdata;
        end
        t_rdata <= tmem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mmem[m_waddr] <= m_wdata;
        end
        m_rdata <= mmem[m_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fmem[f_waddr] <= f_wdata;
        end
        f_rdata <= fmem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[q_waddr] <= q_wdata;
        end
        q_rdata <= qmem[q_raddr];
    end

    function automatic logic [TA_W-1:0] t_addr(input logic [NODE_W-1:0] node,
                                               input logic [SYM_W-1:0] c);
        t_addr = TA_W'(node) * TA_W'(ALPHABET) + TA_W'(c);
    endfunction

    // entry holds child + 1, zero reads as the root
    function automatic logic [NODE_W-1:0] follow(input logic [CNT_W-1:0] e);
        follow = (e == '0) ? '0 : NODE_W'(e - CNT_W'(1));
    endfunction

    state_t            state_reg, state_next;
    logic [TA_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]  nc_reg, nc_next;
    logic              built_reg, built_next;
    logic [NODE_W-1:0] ins_reg, ins_next;
    logic [NODE_W-1:0] scan_reg, scan_next;
    logic [msm_pkg::MASK_W-1:0] acc_reg, acc_next;
    logic              drop_reg, drop_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  tail_reg, tail_next;
    logic [SYM_W-1:0]  c_reg, c_next;
    logic              done_reg, done_next;

    msm_pkg::item_t    item_reg, item_next;
    msm_pkg::result_t  res_reg, res_next;
    logic [NODE_W-1:0] u_reg, u_next;
    logic [NODE_W-1:0] fu_reg, fu_next;
    logic [NODE_W-1:0] v_reg, v_next;
    logic [CNT_W-1:0]  e_reg, e_next;
    logic [msm_pkg::MASK_W-1:0] mf_reg, mf_next;

    logic in_ascii, reg_cid_ok, last_c;
    logic [NODE_W-1:0] fv;

    assign in_ascii   = {1'b0, item.symbol} < 9'(ALPHABET);
    assign reg_cid_ok = {1'b0, item_reg.country_id} < 7'(NUM_LABELS);
    assign last_c     = (c_reg == SYM_W'(ALPHABET - 1));
    assign fv         = follow(t_rdata);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        nc_next    = nc_reg;
        built_next = built_reg;
        ins_next   = ins_reg;
        scan_next  = scan_reg;
        acc_next   = acc_reg;
        drop_next  = drop_reg;
        ovf_next   = ovf_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        c_next     = c_reg;
        done_next  = 1'b0;
        item_next  = item_reg;
        res_next   = res_reg;
        u_next     = u_reg;
        fu_next    = fu_reg;
        v_next     = v_reg;
        e_next     = e_reg;
        mf_next    = mf_reg;

        t_raddr = '0;
        t_waddr = '0;
        t_wdata = '0;
        t_we    = 1'b0;
        m_raddr = '0;
        m_waddr = '0;
        m_wdata = '0;
        m_we    = 1'b0;
        f_raddr = '0;
        f_waddr = '0;
        f_wdata = '0;
        f_we    = 1'b0;
        q_raddr = '0;
        q_waddr = '0;
        q_wdata = '0;
        q_we    = 1'b0;

        res_next.nodes_used = msm_pkg::COUNT_W'(nc_reg);
        res_next.overflow   = ovf_reg;

        case (state_reg)
            S_CLEAR:
            begin
                t_we    = 1'b1;
                t_waddr = clr_reg;
                if (clr_reg < TA_W'(MAX_NODES))
                begin
                    m_we    = 1'b1;
                    m_waddr = NODE_W'(clr_reg);
                end
                if (clr_reg == TA_W'(T_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + TA_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    case (item.opcode)
                        msm_pkg::OP_PATTERN:
                        begin
                            if (!built_reg)
                            begin
                                if (!drop_reg && in_ascii)
                                begin
                                    t_raddr    = t_addr(ins_reg, item.symbol[SYM_W-1:0]);
                                    state_next = S_PAT_RD;
                                end
                                else if (item.final_item)
                                begin
                                    state_next = S_PAT_END;
                                end
                            end
                        end
                        msm_pkg::OP_BUILD:
                        begin
                            if (built_reg)
                            begin
                                done_next            = 1'b1;
                                res_next.result_kind = msm_pkg::RK_BUILD;
                                res_next.found_mask  = '0;
                            end
                            else
                            begin
                                built_next = 1'b1;
                                c_next     = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                state_next = S_B_ROOT_RD;
                            end
                        end
                        msm_pkg::OP_TEXT:
                        begin
                            if (built_reg && nc_reg > CNT_W'(1) && in_ascii)
                            begin
                                t_raddr    = t_addr(scan_reg, item.symbol[SYM_W-1:0]);
                                state_next = S_SCAN_RD;
                            end
                            else
                            begin
                                // non-ascii byte or idle automaton: back to the root
                                scan_next = '0;
                                if (item.final_item)
                                begin
                                    done_next            = 1'b1;
                                    res_next.result_kind = msm_pkg::RK_TEXT;
                                    res_next.found_mask  = acc_reg;
                                    acc_next             = '0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_PAT_RD:
            begin
                if (t_rdata == '0)
                begin
                    if (nc_reg >= CNT_W'(MAX_NODES))
                    begin
                        drop_next = 1'b1;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        t_we     = 1'b1;
                        t_waddr  = t_addr(ins_reg, item_reg.symbol[SYM_W-1:0]);
                        t_wdata  = nc_reg + CNT_W'(1);
                        nc_next  = nc_reg + CNT_W'(1);
                        ins_next = NODE_W'(nc_reg);
                    end
                end
                else
                begin
                    ins_next = follow(t_rdata);
                end
                state_next = item_reg.final_item ? S_PAT_END : S_IDLE;
            end

            S_PAT_END:
            begin
                if (!drop_reg && ins_reg != '0 && reg_cid_ok)
                begin
                    m_raddr    = ins_reg;
                    state_next = S_PAT_MRD;
                end
                else
                begin
                    ins_next   = '0;
                    drop_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            S_PAT_MRD:
            begin
                m_we       = 1'b1;
                m_waddr    = ins_reg;
                m_wdata    = m_rdata | (msm_pkg::MASK_W'(1) << item_reg.country_id);
                ins_next   = '0;
                drop_next  = 1'b0;
                state_next = S_IDLE;
            end

            S_SCAN_RD:
            begin
                scan_next  = fv;
                m_raddr    = fv;
                state_next = S_SCAN_MRD;
            end

            S_SCAN_MRD:
            begin
                if (item_reg.final_item)
                begin
                    done_next            = 1'b1;
                    res_next.result_kind = msm_pkg::RK_TEXT;
                    res_next.found_mask  = acc_reg | m_rdata;
                    acc_next             = '0;
                    scan_next            = '0;
                end
                else
                begin
                    acc_next = acc_reg | m_rdata;
                end
                state_next = S_IDLE;
            end

            S_B_ROOT_RD:
            begin
                t_raddr    = t_addr('0, c_reg);
                state_next = S_B_ROOT_CHK;
            end

            S_B_ROOT_CHK:
            begin
                if (t_rdata != '0)
                begin
                    f_we    = 1'b1;
                    f_waddr = fv;
                    if (tail_reg < CNT_W'(MAX_NODES))
                    begin
                        q_we      = 1'b1;
                        q_waddr   = NODE_W'(tail_reg);
                        q_wdata   = fv;
                        tail_next = tail_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    t_we    = 1'b1;
                    t_waddr = t_addr('0, c_reg);
                    t_wdata = CNT_W'(1);
                end
                if (last_c)
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    c_next     = c_reg + SYM_W'(1);
                    state_next = S_B_ROOT_RD;
                end
            end

            S_B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    q_raddr    = NODE_W'(head_reg);
                    head_next  = head_reg + CNT_W'(1);
                    state_next = S_B_FAIL;
                end
                else
                begin
                    done_next            = 1'b1;
                    res_next.result_kind = msm_pkg::RK_BUILD;
                    res_next.found_mask  = '0;
                    state_next           = S_IDLE;
                end
            end

            S_B_FAIL:
            begin
                u_next     = q_rdata;
                f_raddr    = q_rdata;
                state_next = S_B_FU;
            end

            S_B_FU:
            begin
                fu_next    = f_rdata;
                c_next     = '0;
                state_next = S_B_RD;
            end

            S_B_RD:
            begin
                t_raddr    = t_addr(u_reg, c_reg);
                state_next = S_B_CHK;
            end

            S_B_CHK:
            begin
                e_next     = t_rdata;
                t_raddr    = t_addr(fu_reg, c_reg);
                state_next = S_B_FRD;
            end

            S_B_FRD:
            begin
                if (e_reg == '0)
                begin
                    // missing transition copies the failure target's
                    t_we    = 1'b1;
                    t_waddr = t_addr(u_reg, c_reg);
                    t_wdata = CNT_W'(fv) + CNT_W'(1);
                    if (last_c)
                    begin
                        state_next = S_B_POP;
                    end
                    else
                    begin
                        c_next     = c_reg + SYM_W'(1);
                        state_next = S_B_RD;
                    end
                end
                else
                begin
                    if (tail_reg < CNT_W'(MAX_NODES))
                    begin
                        q_we      = 1'b1;
                        q_waddr   = NODE_W'(tail_reg);
                        q_wdata   = follow(e_reg);
                        tail_next = tail_reg + CNT_W'(1);
                    end
                    f_we       = 1'b1;
                    f_waddr    = follow(e_reg);
                    f_wdata    = fv;
                    v_next     = follow(e_reg);
                    m_raddr    = fv;
                    state_next = S_B_M1;
                end
            end

            S_B_M1:
            begin
                mf_next    = m_rdata;
                m_raddr    = v_reg;
                state_next = S_B_M2;
            end

            S_B_M2:
            begin
                m_we    = 1'b1;
                m_waddr = v_reg;
                m_wdata = m_rdata | mf_reg;
                if (last_c)
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    c_next     = c_reg + SYM_W'(1);
                    state_next = S_B_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            nc_reg    <= CNT_W'(1);
            built_reg <= 1'b0;
            ins_reg   <= '0;
            scan_reg  <= '0;
            acc_reg   <= '0;
            drop_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            c_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nc_reg    <= nc_next;
            built_reg <= built_next;
            ins_reg   <= ins_next;
            scan_reg  <= scan_next;
            acc_reg   <= acc_next;
            drop_reg  <= drop_next;
            ovf_reg   <= ovf_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            c_reg     <= c_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        u_reg    <= u_next;
        fu_reg   <= fu_next;
        v_reg    <= v_next;
        e_reg    <= e_next;
        mf_reg   <= mf_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        nc_reg >= CNT_W'(1) && nc_reg <= CNT_W'(MAX_NODES))
        else $error("node count out of range");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !done_reg)
        else $error("result during memory clear");

    a_build_result_built: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.result_kind == msm_pkg::RK_BUILD |-> built_reg)
        else $error("build result without built automaton");

    a_mask_needs_build: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.result_kind == msm_pkg::RK_TEXT && res_reg.found_mask != '0
        |-> built_reg)
        else $error("match reported before build");

endmodule
